FILE: src/round_robin_thread_scheduler_defines.svh
// ----------------------------------------------------------------------------
// round robin thread scheduler assertion macros
// shared checks, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH

// condition implies consequence in the same cycle
`define RRTS_ASSERT_NOW(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define RRTS_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// types and constants shared by the round robin thread scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

	localparam int THREADS_DEF = 16;
	localparam int CYC_W       = 48;
	localparam int TID_W       = 4;

	typedef enum logic [1:0] {
		CMD_SPAWN  = 2'd0,
		CMD_EXIT   = 2'd1,
		CMD_JOIN   = 2'd2,
		CMD_SWITCH = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_READY   = 2'd0,
		ST_RUNNING = 2'd1,
		ST_BLOCKED = 2'd2
	} slot_state_t;

	typedef struct packed {
		cmd_code_t          cmd;
		logic [TID_W-1:0]   target_thread;
		logic [CYC_W-1:0]   now_cycle;
	} req_t;

	typedef struct packed {
		logic [TID_W-1:0]   result_thread;
		logic               ok;
		logic               switched;
		logic               none_ready;
		logic [CYC_W-1:0]   old_thread_cycles;
	} rsp_t;

endpackage

`default_nettype wire

FILE: src/rrts_ring.sv
// ----------------------------------------------------------------------------
// rrts_ring
// ring of thread ids, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ring #(
	parameter int THREADS = rrts_pkg::THREADS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(THREADS)-1:0] waddr,
	input  wire logic [$clog2(THREADS)-1:0] wdata,
	input  wire logic [$clog2(THREADS)-1:0] raddr,
	output logic      [$clog2(THREADS)-1:0] rdata
);
	import rrts_pkg::*;

	localparam int ID_W = $clog2(THREADS);

	logic [ID_W-1:0] mem [THREADS];
	logic [ID_W-1:0] rdata_q;

	// write-first: a read of the entry being written sees the new id
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: src/rrts_acct.sv
// ----------------------------------------------------------------------------
// rrts_acct
// per-thread cycle totals, entries read as zero until written
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_acct #(
	parameter int THREADS = rrts_pkg::THREADS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       clr,
	input  wire logic [$clog2(THREADS)-1:0] clr_idx,
	input  wire logic                       we,
	input  wire logic [$clog2(THREADS)-1:0] waddr,
	input  wire logic [rrts_pkg::CYC_W-1:0] wdata,
	input  wire logic [$clog2(THREADS)-1:0] raddr,
	output logic      [rrts_pkg::CYC_W-1:0] rdata
);
	import rrts_pkg::*;

	logic [CYC_W-1:0]   mem [THREADS];
	logic [CYC_W-1:0]   rdata_q;
	logic [THREADS-1:0] valid_q;
	logic               rvalid_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= valid_q[raddr];
			if (clr) begin
				valid_q[clr_idx] <= 1'b0;
			end
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rvalid_s1 ? rdata_q : '0;

endmodule

`default_nettype wire

FILE: src/round_robin_thread_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// thread table with spawn, exit, join and round robin switch
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_valid / req_stall | req_t  (cmd, target_thread, now_cycle)
//  rsp     | out | rsp_valid / rsp_stall | rsp_t  (one item per request)
//
// spawn, exit and join load the result register on accept and go to S_DONE.
// switch passes S_ACC and S_ADD, then S_RDQ and S_EVAL for the ring walk:
// S_EVAL visits ring entries (1 .. ring count), one entry read per cycle and
// skipped entries requeued; with an empty ring S_ADD goes to S_DONE. S_DONE
// loads the output register and returns to S_IDLE, which takes the next item.
// reset is immediate, no clearing pass; cycle totals use per-slot valid bits.
// a stalled result holds the block only when a second result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_thread_scheduler #(
	parameter int THREADS = rrts_pkg::THREADS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire rrts_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output rrts_pkg::rsp_t      rsp
);
	import rrts_pkg::*;

	`include "round_robin_thread_scheduler_defines.svh"

	localparam int ID_W = $clog2(THREADS);
	localparam int CNT_W = ID_W + 1;
	localparam logic [CNT_W-1:0] TCNT = CNT_W'(THREADS);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ACC  = 6'b000010,
		S_ADD  = 6'b000100,
		S_RDQ  = 6'b001000,
		S_EVAL = 6'b010000,
		S_DONE = 6'b100000
	} fsm_t;

	fsm_t             fsm_q;
	logic [THREADS-1:0] used_q;
	slot_state_t      st_q [THREADS];
	logic [THREADS-1:0] wt_v_q;
	logic [ID_W-1:0]  wt_id_q [THREADS];
	logic [ID_W-1:0]  head_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] steps_q;
	logic [ID_W-1:0]  running_q;
	logic             run_in_q;
	logic [CYC_W-1:0] last_q;
	logic [CYC_W-1:0] now_q;
	logic [CYC_W-1:0] oc_q;
	logic [CYC_W-1:0] d_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             accept;
	logic [ID_W-1:0]  tail;
	logic [ID_W-1:0]  head_inc;
	logic             free_found;
	logic [ID_W-1:0]  free_idx;
	logic             hit;
	logic             last;
	logic [ID_W-1:0]  tgt_id;
	logic             tgt_live;
	logic             spawn_ok;
	logic             exit_ok;
	logic             join_ok;
	logic [CYC_W:0]   sum;
	logic [CYC_W-1:0] sat;

	logic             ring_we;
	logic [ID_W-1:0]  ring_waddr;
	logic [ID_W-1:0]  ring_wdata;
	logic [ID_W-1:0]  ring_raddr;
	logic [ID_W-1:0]  ring_rdata;
	logic             acct_clr;
	logic             acct_we;
	logic [CYC_W-1:0] acct_rdata;

	function automatic logic [ID_W-1:0] wrap(input logic [CNT_W-1:0] s);
		logic [CNT_W-1:0] r;
		r = (s >= TCNT) ? (s - TCNT) : s;
		return ID_W'(r);
	endfunction

	function automatic rsp_t mk_rsp(input logic [ID_W-1:0] tid, input logic okv);
		rsp_t r;
		r = '0;
		r.result_thread = TID_W'(tid);
		r.ok = okv;
		return r;
	endfunction

	assign accept    = req_valid && !req_stall;
	assign req_stall = (fsm_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign tail     = wrap(CNT_W'(head_q) + count_q);
	assign head_inc = wrap(CNT_W'(head_q) + CNT_W'(1));
	assign hit      = used_q[ring_rdata] && (st_q[ring_rdata] != ST_BLOCKED);
	assign last     = ((steps_q + CNT_W'(1)) == count_q);
	assign tgt_id   = ID_W'(req.target_thread);
	assign tgt_live = (int'(req.target_thread) < THREADS) && used_q[tgt_id];
	assign spawn_ok = free_found && (count_q < TCNT);
	assign exit_ok  = run_in_q && used_q[running_q] && (st_q[running_q] == ST_RUNNING);
	assign join_ok  = run_in_q && tgt_live;
	assign sum      = {1'b0, oc_q} + {1'b0, d_q};
	assign sat      = sum[CYC_W] ? '1 : sum[CYC_W-1:0];

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = THREADS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = ID_W'(i);
			end
		end
	end

	always_comb begin
		ring_we    = 1'b0;
		ring_waddr = tail;
		ring_wdata = running_q;
		ring_raddr = head_q;
		acct_clr   = 1'b0;
		acct_we    = 1'b0;
		unique case (fsm_q)
			S_IDLE: begin
				if (accept && (req.cmd == CMD_SPAWN) && spawn_ok) begin
					ring_we    = 1'b1;
					ring_wdata = free_idx;
					acct_clr   = 1'b1;
				end
			end
			S_ADD: begin
				ring_we = run_in_q;
				acct_we = run_in_q;
			end
			S_EVAL: begin
				// requeue a skipped entry; the final entry stays when the old thread returns
				if (!hit && !(last && run_in_q)) begin
					ring_we    = 1'b1;
					ring_wdata = ring_rdata;
					ring_raddr = head_inc;
				end
			end
			default: begin
			end
		endcase
	end

	rrts_ring #(
		.THREADS(THREADS)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_waddr),
		.wdata(ring_wdata),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	rrts_acct #(
		.THREADS(THREADS)
	) u_acct (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (acct_clr),
		.clr_idx(free_idx),
		.we     (acct_we),
		.waddr  (running_q),
		.wdata  (sat),
		.raddr  (running_q),
		.rdata  (acct_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= S_IDLE;
			used_q      <= THREADS'(1);
			for (int i = 0; i < THREADS; i++) begin
				st_q[i]    <= (i == 0) ? ST_RUNNING : ST_READY;
				wt_id_q[i] <= '0;
			end
			wt_v_q      <= '0;
			head_q      <= '0;
			count_q     <= CNT_W'(1);
			steps_q     <= '0;
			running_q   <= '0;
			run_in_q    <= 1'b1;
			last_q      <= '0;
			now_q       <= '0;
			oc_q        <= '0;
			d_q         <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((fsm_q == S_DONE) && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (fsm_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.cmd)
							CMD_SPAWN: begin
								if (spawn_ok) begin
									used_q[free_idx] <= 1'b1;
									st_q[free_idx]   <= ST_READY;
									wt_v_q[free_idx] <= 1'b0;
									count_q          <= count_q + CNT_W'(1);
									res_q            <= mk_rsp(free_idx, 1'b1);
								end else begin
									res_q <= mk_rsp('0, 1'b0);
								end
								fsm_q <= S_DONE;
							end
							CMD_EXIT: begin
								res_q <= mk_rsp(running_q, exit_ok);
								if (exit_ok) begin
									// free the exiting thread, wake every thread joined on it
									for (int i = 0; i < THREADS; i++) begin
										if (ID_W'(i) == running_q) begin
											used_q[i] <= 1'b0;
											st_q[i]   <= ST_READY;
											wt_v_q[i] <= 1'b0;
										end else if (wt_v_q[i] && (wt_id_q[i] == running_q)) begin
											wt_v_q[i] <= 1'b0;
											st_q[i]   <= ST_READY;
										end
									end
									head_q   <= head_inc;
									count_q  <= count_q - CNT_W'(1);
									run_in_q <= 1'b0;
								end
								fsm_q <= S_DONE;
							end
							CMD_JOIN: begin
								res_q <= mk_rsp(running_q, join_ok);
								if (join_ok) begin
									wt_v_q[running_q]  <= 1'b1;
									wt_id_q[running_q] <= tgt_id;
									st_q[running_q]    <= ST_BLOCKED;
								end
								fsm_q <= S_DONE;
							end
							CMD_SWITCH: begin
								res_q <= '0;
								now_q <= req.now_cycle;
								fsm_q <= S_ACC;
							end
						endcase
					end
				end
				S_ACC: begin
					oc_q   <= acct_rdata;
					d_q    <= now_q - last_q;
					last_q <= now_q;
					if (run_in_q && (st_q[running_q] != ST_BLOCKED)) begin
						st_q[running_q] <= ST_READY;
					end
					fsm_q <= S_ADD;
				end
				S_ADD: begin
					// old thread goes to the tail
					if (run_in_q) begin
						head_q <= head_inc;
					end
					steps_q <= '0;
					res_q.old_thread_cycles <= oc_q;
					res_q.result_thread     <= TID_W'(running_q);
					if (count_q == '0) begin
						res_q.none_ready <= 1'b1;
						fsm_q <= S_DONE;
					end else begin
						fsm_q <= S_RDQ;
					end
				end
				S_RDQ: begin
					fsm_q <= S_EVAL;
				end
				S_EVAL: begin
					if (hit) begin
						st_q[ring_rdata]    <= ST_RUNNING;
						running_q           <= ring_rdata;
						run_in_q            <= 1'b1;
						res_q.result_thread <= TID_W'(ring_rdata);
						res_q.switched      <= (ring_rdata != running_q);
						fsm_q <= S_DONE;
					end else begin
						if (!(last && run_in_q)) begin
							head_q <= head_inc;
						end
						steps_q <= steps_q + CNT_W'(1);
						if (last) begin
							res_q.none_ready <= 1'b1;
							fsm_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q <= res_q;
						fsm_q <= S_IDLE;
					end
				end
				default: begin
					fsm_q <= S_IDLE;
				end
			endcase
		end
	end

	`RRTS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= TCNT, "ring count above thread count")
	`RRTS_ASSERT_NOW(a_walk_bound, fsm_q == S_EVAL, steps_q < count_q,
		"ring walk past ring count")
	`RRTS_ASSERT_NOW(a_run_used, run_in_q, used_q[running_q],
		"running thread slot not in use")
	`RRTS_ASSERT_NEXT(a_rsp_from_done, !rsp_valid_q && fsm_q != S_DONE, !rsp_valid_q,
		"result item without finished command")

endmodule

`default_nettype wire
